// ===== rtl/kmod_pkg.sv =====
// ----------------------------------------------------------------------------
// kmod_pkg
// Shared types and constants of the key matrix overscan debouncer.
// ----------------------------------------------------------------------------
package kmod_pkg;

  localparam int unsigned OVERSCAN_DEPTH = 4;
  localparam int unsigned COLS           = 2;
  localparam int unsigned ROW_W          = 8;
  localparam int unsigned STATUS_W       = COLS * ROW_W;
  localparam int unsigned IN_DATA_W      = 8;
  localparam int unsigned OUT_DATA_W     = 56;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [COLS-1:0][ROW_W-1:0] col_bytes_t;

  // running all-ones / any-one reduction passed along the cell row
  typedef struct packed {
    col_bytes_t all_high;
    col_bytes_t any_high;
  } acc_t;

  typedef struct packed {
    logic                next_column;
    logic [STATUS_W-1:0] rising_edges;
    logic [STATUS_W-1:0] previous_status;
    logic [STATUS_W-1:0] debounced;
  } result_t;

endpackage

// ===== rtl/kmod_cell.sv =====
// ----------------------------------------------------------------------------
// kmod_cell
// One oversampling slot per column; shifts from its neighbour on a scan item
// of that column and folds its sample into the passing reduction.
// ----------------------------------------------------------------------------
module kmod_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         shift_i,
  input  kmod_pkg::col_bytes_t sample_i,
  output kmod_pkg::col_bytes_t sample_o,
  input  kmod_pkg::acc_t     acc_i,
  output kmod_pkg::acc_t     acc_o
);
  import kmod_pkg::*;

  col_bytes_t sample_d, sample_q;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      sample_d[c]       = shift_i[c] ? sample_i[c] : sample_q[c];
      acc_o.all_high[c] = acc_i.all_high[c] & sample_d[c];
      acc_o.any_high[c] = acc_i.any_high[c] | sample_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

// ===== rtl/kmod_obuf.sv =====
// ----------------------------------------------------------------------------
// kmod_obuf
// Output register with a skid stage, so the input side can take one more item
// while a result waits.
// ----------------------------------------------------------------------------
module kmod_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kmod_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kmod_pkg::result_t out_data_o,
  output logic              skid_valid_o
);
  import kmod_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, skid_q;
  logic    in_fire, out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
      end else begin
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign skid_valid_o = skid_valid_q;

endmodule

// ===== rtl/key_matrix_overscan_debounce.sv =====
// ----------------------------------------------------------------------------
// key_matrix_overscan_debounce
// Two-column key matrix scanner with oversampling debounce.
//
// channel   dir  accept              tdata / tuser
// s_axis    in   tvalid & tready     tdata[7:0] row_bits, tuser mode
// m_axis    out  tvalid & tready     tdata debounced, previous_status,
//                                    rising_edges, next_column
//
// One item per cycle while s_axis_tready is high; each result is registered.
// The sample history is a row of OVERSCAN_DEPTH cells; the status reduction
// ripples through the row in the accepting cycle.
// Reset clears history, column, status and saved status.
// A stalled output fills one skid entry, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module key_matrix_overscan_debounce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [kmod_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [7:0] row_bits
  input  logic                                s_axis_tuser_i,  // mode
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [15:0] debounced, [31:16] previous_status, [47:32] rising_edges,
  // [48] next_column, [55:49] zero
  output logic [kmod_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import kmod_pkg::*;

  logic                in_fire, scan_fire, read_fire;
  logic                col_q, col_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [STATUS_W-1:0] last_q, last_d;
  logic [1:0]          shift;
  col_bytes_t          sample_chain [OVERSCAN_DEPTH+1];
  acc_t                acc_chain    [OVERSCAN_DEPTH+1];
  result_t             res, out_res;
  logic                skid_valid;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_fire = in_fire && (s_axis_tuser_i == MODE_SCAN);
  assign read_fire = in_fire && (s_axis_tuser_i == MODE_READ);

  assign shift[0] = scan_fire && !col_q;
  assign shift[1] = scan_fire && col_q;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      sample_chain[0][c]       = s_axis_tdata_i[ROW_W-1:0];
      acc_chain[0].all_high[c] = '1;
      acc_chain[0].any_high[c] = '0;
    end
  end

  for (genvar i = 0; i < OVERSCAN_DEPTH; i++) begin : g_cell
    kmod_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .sample_i (sample_chain[i]),
      .sample_o (sample_chain[i+1]),
      .acc_i    (acc_chain[i]),
      .acc_o    (acc_chain[i+1])
    );
  end

  always_comb begin
    status_d = status_q;
    if (scan_fire) begin
      for (int c = 0; c < COLS; c++) begin
        status_d[c*ROW_W +: ROW_W] =
          (status_q[c*ROW_W +: ROW_W] | acc_chain[OVERSCAN_DEPTH].all_high[c])
          & acc_chain[OVERSCAN_DEPTH].any_high[c];
      end
    end
  end

  assign col_d  = scan_fire ? !col_q : col_q;
  assign last_d = read_fire ? status_q : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= 1'b0;
      status_q <= '0;
      last_q   <= '0;
    end else begin
      col_q    <= col_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign res.debounced       = status_d;
  assign res.previous_status = last_q;
  assign res.rising_edges    = status_d & ~last_q;
  assign res.next_column     = col_d;

  kmod_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (res),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (out_res),
    .skid_valid_o (skid_valid)
  );

  assign m_axis_tdata_o = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid |-> m_axis_tvalid_o)
    else $error("skid entry held without a pending output item");

  a_read_holds_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_fire |=> (status_q == $past(status_q)) && (col_q == $past(col_q)))
    else $error("read item changed the debounced status or column");

  a_scan_toggles_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fire |=> col_q != $past(col_q))
    else $error("scan item did not advance the column");

  a_scan_keeps_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fire |=> last_q == $past(last_q))
    else $error("scan item changed the saved status");

endmodule
